>>> rtl/bps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

    localparam int DIR_FRAC_BITS_DEF   = 14;
    localparam int COLOR_FRAC_BITS_DEF = 14;

    // front end widths
    localparam int H_W    = 17;   // L - R per axis
    localparam int SQ_W   = 32;   // h*h
    localparam int LSQ_W  = 34;   // |H|^2
    localparam int DH_W   = 34;   // N.H, signed
    localparam int DL_W   = 33;   // N.L, signed
    localparam int AD_W   = 33;   // positive N.H
    localparam int DSQ_W  = 66;   // (N.H)^2
    localparam int NDL_W  = 24;   // N.L after the fraction shift

    // normalize: quotient (N.H)^2 * 2^60 / |H|^2, then its root
    localparam int DIV_STEPS = 60;
    localparam int Q_W       = 60;
    localparam int RT_W      = 30;

    // power unit, Q.30 values
    localparam int FX_FRAC       = 30;
    localparam int X_W           = 31;
    localparam int INT_STEPS     = 128;
    localparam int FRAC_STEPS    = 8;
    localparam int FR_SQ_STEPS   = 31;
    localparam int FR_RAD_W      = 62;
    localparam int FR_RM_W       = 32;
    localparam logic [X_W-1:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [15:0]    E_MAX   = 16'h8000;

    // output stage
    localparam int PRE_SHIFT = 4;
    localparam int LS_W      = 32;
    localparam int S_W       = 59;
    localparam int D_W       = 56;
    localparam int SUM_W     = 60;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPEC_RED,
        REG_SPEC_GREEN,
        REG_SPEC_BLUE,
        REG_DIFF_RED,
        REG_DIFF_GREEN,
        REG_DIFF_BLUE,
        REG_SHININESS
    } cfg_reg_t;

    typedef struct packed {
        logic signed [15:0] ray_dir_x;
        logic signed [15:0] ray_dir_y;
        logic signed [15:0] ray_dir_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic signed [15:0] light_dir_x;
        logic signed [15:0] light_dir_y;
        logic signed [15:0] light_dir_z;
        logic [15:0]        light_red;
        logic [15:0]        light_green;
        logic [15:0]        light_blue;
    } in_t;

    typedef struct packed {
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
    } out_t;

    // item data riding along the pipeline
    typedef struct packed {
        logic [2:0][15:0]   light;
        logic [NDL_W-1:0]   ndotl;
        logic               nz;
        logic               pos;
        logic               clamp;
    } side_t;

endpackage

`default_nettype wire

>>> rtl/blinn_phong_shader.sv
`timescale 1ns / 1ps
`default_nettype none
// Blinn-Phong shader, one light, fixed point.
// Input channel s_*: one beat per surface hit (ray, normal, light direction,
// light color). Result channel m_*: one beat of RGB per input beat, in order.
// Config channel cfg_*: always ready; index 0..6 selects specular RGB,
// diffuse RGB, shininess. Write only while the pipeline is empty.
// Depth: 484 register stages including the output register. Throughput: one
// beat per cycle while the receiver takes results. The depth is set by the
// normalizing divider (60 stages), its root (30 stages), 128 integer power
// multiplies and 8 fractional roots of 31 stages each followed by a multiply,
// plus 10 front/back stages.
// Every stage carries a valid bit; the whole pipeline advances when the
// output register is empty or being taken. A stalled receiver holds the
// result and freezes the pipeline; s_ready drops in the same cycle, nothing
// is lost or repeated.
// Reset clears all valid bits and loads the config registers (colors 0,
// shininess 1.0).
module blinn_phong_shader
    import bps_pkg::*;
#(
    parameter int DIR_FRAC_BITS   = DIR_FRAC_BITS_DEF,
    parameter int COLOR_FRAC_BITS = COLOR_FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_t                  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    logic adv;
    logic m_valid_reg;
    out_t m_data_reg;

    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = adv;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // ---------------- config registers ----------------
    logic [2:0][15:0] spec_reg;
    logic [2:0][15:0] diff_reg;
    logic [15:0]      shin_reg;
    logic [15:0]      e_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spec_reg <= '0;
            diff_reg <= '0;
            shin_reg <= 16'h0100;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SPEC_RED:   spec_reg[0] <= cfg_data;
                REG_SPEC_GREEN: spec_reg[1] <= cfg_data;
                REG_SPEC_BLUE:  spec_reg[2] <= cfg_data;
                REG_DIFF_RED:   diff_reg[0] <= cfg_data;
                REG_DIFF_GREEN: diff_reg[1] <= cfg_data;
                REG_DIFF_BLUE:  diff_reg[2] <= cfg_data;
                REG_SHININESS:  shin_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign e_eff = (shin_reg > E_MAX) ? E_MAX : shin_reg;

    // ---------------- front: dot products ----------------
    logic signed [15:0] in_r [3];
    logic signed [15:0] in_n [3];
    logic signed [15:0] in_l [3];

    assign in_r[0] = s_data.ray_dir_x;
    assign in_r[1] = s_data.ray_dir_y;
    assign in_r[2] = s_data.ray_dir_z;
    assign in_n[0] = s_data.norm_x;
    assign in_n[1] = s_data.norm_y;
    assign in_n[2] = s_data.norm_z;
    assign in_l[0] = s_data.light_dir_x;
    assign in_l[1] = s_data.light_dir_y;
    assign in_l[2] = s_data.light_dir_z;

    logic [4:0] fv_reg;

    logic signed [H_W-1:0] h1_reg [3];
    logic signed [15:0]    n1_reg [3];
    logic signed [15:0]    l1_reg [3];
    logic [2:0][15:0]      col1_reg;

    logic signed [2*H_W-1:0] hh_c [3];
    logic signed [H_W+15:0]  hn_c [3];
    logic signed [31:0]      nl_c [3];

    logic [SQ_W-1:0]        hh2_reg [3];
    logic signed [H_W+15:0] hn2_reg [3];
    logic signed [31:0]     nl2_reg [3];
    logic [2:0][15:0]       col2_reg;

    logic [LSQ_W-1:0]       lsq3_reg;
    logic signed [DH_W-1:0] dh3_reg;
    logic signed [DL_W-1:0] dl3_reg;
    logic [2:0][15:0]       col3_reg;

    logic signed [DL_W-1:0] dl_sh;
    side_t                  side4_next;
    logic [AD_W-1:0]        ad4_reg;
    logic [LSQ_W-1:0]       lsq4_reg;
    side_t                  side4_reg;

    logic [DSQ_W-1:0]       dsq5_reg;
    logic [LSQ_W-1:0]       lsq5_reg;
    side_t                  side5_reg;

    logic                   clamp6;
    side_t                  side6_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= '0;
        end else if (adv) begin
            fv_reg <= {fv_reg[3:0], s_valid};
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            hh_c[k] = h1_reg[k] * h1_reg[k];
            hn_c[k] = h1_reg[k] * n1_reg[k];
            nl_c[k] = n1_reg[k] * l1_reg[k];
        end
    end

    assign dl_sh = dl3_reg >>> DIR_FRAC_BITS;

    always_comb begin
        side4_next.light = col3_reg;
        side4_next.ndotl = (dl3_reg > 0) ? dl_sh[NDL_W-1:0] : '0;
        side4_next.nz    = (lsq3_reg != '0);
        side4_next.pos   = (dh3_reg > 0);
        side4_next.clamp = 1'b0;
    end

    // clamp: x = 1.0 satisfies the bound exactly when (N.H)^2 >= |H|^2
    assign clamp6 = (dsq5_reg >= DSQ_W'(lsq5_reg));

    always_comb begin
        side6_next       = side5_reg;
        side6_next.clamp = clamp6;
    end

    // ---------------- divider arrays ----------------
    logic [LSQ_W-1:0] dv_rem_reg  [0:DIV_STEPS];
    logic [Q_W-1:0]   dv_q_reg    [0:DIV_STEPS];
    logic [LSQ_W-1:0] dv_lsq_reg  [0:DIV_STEPS];
    side_t            dv_side_reg [0:DIV_STEPS];
    logic             dv_v_reg    [0:DIV_STEPS];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                h1_reg[k]  <= H_W'(in_l[k]) - H_W'(in_r[k]);
                n1_reg[k]  <= in_n[k];
                l1_reg[k]  <= in_l[k];
                hh2_reg[k] <= hh_c[k][SQ_W-1:0];
                hn2_reg[k] <= hn_c[k];
                nl2_reg[k] <= nl_c[k];
            end
            col1_reg <= {s_data.light_blue, s_data.light_green, s_data.light_red};
            col2_reg <= col1_reg;
            lsq3_reg <= LSQ_W'(hh2_reg[0]) + LSQ_W'(hh2_reg[1]) + LSQ_W'(hh2_reg[2]);
            dh3_reg  <= DH_W'(hn2_reg[0]) + DH_W'(hn2_reg[1]) + DH_W'(hn2_reg[2]);
            dl3_reg  <= DL_W'(nl2_reg[0]) + DL_W'(nl2_reg[1]) + DL_W'(nl2_reg[2]);
            col3_reg <= col2_reg;
            ad4_reg  <= (dh3_reg > 0) ? dh3_reg[AD_W-1:0] : '0;
            lsq4_reg <= lsq3_reg;
            side4_reg <= side4_next;
            dsq5_reg <= DSQ_W'(ad4_reg) * DSQ_W'(ad4_reg);
            lsq5_reg <= lsq4_reg;
            side5_reg <= side4_reg;
            dv_rem_reg[0]  <= (side5_reg.pos && !clamp6) ? dsq5_reg[LSQ_W-1:0] : '0;
            dv_q_reg[0]    <= '0;
            dv_lsq_reg[0]  <= lsq5_reg;
            dv_side_reg[0] <= side6_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_v_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_v_reg[0] <= fv_reg[4];
        end
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
        logic [LSQ_W:0] r2;
        logic [LSQ_W:0] df;
        logic           ge;

        assign r2 = {dv_rem_reg[k-1], 1'b0};
        assign df = r2 - {1'b0, dv_lsq_reg[k-1]};
        assign ge = (r2 >= {1'b0, dv_lsq_reg[k-1]});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[k] <= 1'b0;
            end else if (adv) begin
                dv_v_reg[k] <= dv_v_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_rem_reg[k]  <= ge ? df[LSQ_W-1:0] : r2[LSQ_W-1:0];
                dv_q_reg[k]    <= {dv_q_reg[k-1][Q_W-2:0], ge};
                dv_lsq_reg[k]  <= dv_lsq_reg[k-1];
                dv_side_reg[k] <= dv_side_reg[k-1];
            end
        end
    end

    // ---------------- square root of the quotient ----------------
    logic [Q_W-1:0]  sq_rad_reg  [1:RT_W];
    logic [RT_W-1:0] sq_root_reg [1:RT_W];
    logic [RT_W+1:0] sq_rm_reg   [1:RT_W];
    side_t           sq_side_reg [1:RT_W];
    logic            sq_v_reg    [1:RT_W];

    for (genvar k = 1; k <= RT_W; k++) begin : g_sq
        logic [Q_W-1:0]  rad_in;
        logic [RT_W-1:0] root_in;
        logic [RT_W+1:0] rm_in;
        side_t           side_in;
        logic            v_in;
        logic [RT_W+3:0] t;
        logic [RT_W+3:0] trial;
        logic [RT_W+3:0] df;
        logic            ge;

        if (k == 1) begin : g_first
            assign rad_in  = dv_q_reg[DIV_STEPS];
            assign root_in = '0;
            assign rm_in   = '0;
            assign side_in = dv_side_reg[DIV_STEPS];
            assign v_in    = dv_v_reg[DIV_STEPS];
        end else begin : g_next
            assign rad_in  = sq_rad_reg[k-1];
            assign root_in = sq_root_reg[k-1];
            assign rm_in   = sq_rm_reg[k-1];
            assign side_in = sq_side_reg[k-1];
            assign v_in    = sq_v_reg[k-1];
        end

        assign t     = {rm_in, rad_in[Q_W-1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign df    = t - trial;
        assign ge    = (t >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v_reg[k] <= 1'b0;
            end else if (adv) begin
                sq_v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_rad_reg[k]  <= {rad_in[Q_W-3:0], 2'b00};
                sq_root_reg[k] <= {root_in[RT_W-2:0], ge};
                sq_rm_reg[k]   <= ge ? df[RT_W+1:0] : t[RT_W+1:0];
                sq_side_reg[k] <= side_in;
            end
        end
    end

    // ---------------- N.H select, integer power chain ----------------
    logic [X_W-1:0] ia_acc_reg  [0:INT_STEPS];
    logic [X_W-1:0] ia_x_reg    [0:INT_STEPS];
    side_t          ia_side_reg [0:INT_STEPS];
    logic           ia_v_reg    [0:INT_STEPS];
    logic [X_W-1:0] ndoth;
    side_t          sq_last;

    assign sq_last = sq_side_reg[RT_W];
    assign ndoth   = !sq_last.pos ? '0 :
                     (sq_last.clamp ? ONE_Q30 : X_W'(sq_root_reg[RT_W]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ia_v_reg[0] <= 1'b0;
        end else if (adv) begin
            ia_v_reg[0] <= sq_v_reg[RT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ia_acc_reg[0]  <= ONE_Q30;
            ia_x_reg[0]    <= ndoth;
            ia_side_reg[0] <= sq_last;
        end
    end

    for (genvar k = 1; k <= INT_STEPS; k++) begin : g_int
        logic [2*X_W-1:0] prod;
        logic             use_mul;

        assign prod    = (2*X_W)'(ia_acc_reg[k-1]) * (2*X_W)'(ia_x_reg[k-1]);
        assign use_mul = (8'(k - 1) < e_eff[15:8]);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ia_v_reg[k] <= 1'b0;
            end else if (adv) begin
                ia_v_reg[k] <= ia_v_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                ia_acc_reg[k]  <= use_mul ? prod[FX_FRAC +: X_W] : ia_acc_reg[k-1];
                ia_x_reg[k]    <= ia_x_reg[k-1];
                ia_side_reg[k] <= ia_side_reg[k-1];
            end
        end
    end

    // ---------------- fractional power: repeated roots ----------------
    logic [FR_RAD_W-1:0] fs_rad_reg  [FRAC_STEPS][FR_SQ_STEPS];
    logic [X_W-1:0]      fs_root_reg [FRAC_STEPS][FR_SQ_STEPS];
    logic [FR_RM_W-1:0]  fs_rm_reg   [FRAC_STEPS][FR_SQ_STEPS];
    logic [X_W-1:0]      fs_acc_reg  [FRAC_STEPS][FR_SQ_STEPS];
    side_t               fs_side_reg [FRAC_STEPS][FR_SQ_STEPS];
    logic                fs_v_reg    [FRAC_STEPS][FR_SQ_STEPS];

    logic [X_W-1:0] fm_acc_reg  [FRAC_STEPS];
    logic [X_W-1:0] fm_r_reg    [FRAC_STEPS];
    side_t          fm_side_reg [FRAC_STEPS];
    logic           fm_v_reg    [FRAC_STEPS];

    for (genvar i = 0; i < FRAC_STEPS; i++) begin : g_frac
        logic [X_W-1:0] blk_acc;
        logic [X_W-1:0] blk_r;
        side_t          blk_side;
        logic           blk_v;

        if (i == 0) begin : g_src_int
            assign blk_acc  = ia_acc_reg[INT_STEPS];
            assign blk_r    = ia_x_reg[INT_STEPS];
            assign blk_side = ia_side_reg[INT_STEPS];
            assign blk_v    = ia_v_reg[INT_STEPS];
        end else begin : g_src_frac
            assign blk_acc  = fm_acc_reg[i-1];
            assign blk_r    = fm_r_reg[i-1];
            assign blk_side = fm_side_reg[i-1];
            assign blk_v    = fm_v_reg[i-1];
        end

        for (genvar j = 0; j < FR_SQ_STEPS; j++) begin : g_step
            logic [FR_RAD_W-1:0] rad_in;
            logic [X_W-1:0]      root_in;
            logic [FR_RM_W-1:0]  rm_in;
            logic [X_W-1:0]      acc_in;
            side_t               side_in;
            logic                v_in;
            logic [FR_RM_W+1:0]  t;
            logic [FR_RM_W+1:0]  trial;
            logic [FR_RM_W+1:0]  df;
            logic                ge;

            if (j == 0) begin : g_first
                // root of r << 30
                assign rad_in  = {1'b0, blk_r, {FX_FRAC{1'b0}}};
                assign root_in = '0;
                assign rm_in   = '0;
                assign acc_in  = blk_acc;
                assign side_in = blk_side;
                assign v_in    = blk_v;
            end else begin : g_next
                assign rad_in  = fs_rad_reg[i][j-1];
                assign root_in = fs_root_reg[i][j-1];
                assign rm_in   = fs_rm_reg[i][j-1];
                assign acc_in  = fs_acc_reg[i][j-1];
                assign side_in = fs_side_reg[i][j-1];
                assign v_in    = fs_v_reg[i][j-1];
            end

            assign t     = {rm_in, rad_in[FR_RAD_W-1 -: 2]};
            assign trial = {1'b0, root_in, 2'b01};
            assign df    = t - trial;
            assign ge    = (t >= trial);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    fs_v_reg[i][j] <= 1'b0;
                end else if (adv) begin
                    fs_v_reg[i][j] <= v_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    fs_rad_reg[i][j]  <= {rad_in[FR_RAD_W-3:0], 2'b00};
                    fs_root_reg[i][j] <= {root_in[X_W-2:0], ge};
                    fs_rm_reg[i][j]   <= ge ? df[FR_RM_W-1:0] : t[FR_RM_W-1:0];
                    fs_acc_reg[i][j]  <= acc_in;
                    fs_side_reg[i][j] <= side_in;
                end
            end
        end

        logic [2*X_W-1:0] prod;
        assign prod = (2*X_W)'(fs_acc_reg[i][FR_SQ_STEPS-1]) *
                      (2*X_W)'(fs_root_reg[i][FR_SQ_STEPS-1]);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                fm_v_reg[i] <= 1'b0;
            end else if (adv) begin
                fm_v_reg[i] <= fs_v_reg[i][FR_SQ_STEPS-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                fm_acc_reg[i]  <= e_eff[FRAC_STEPS-1-i] ? prod[FX_FRAC +: X_W]
                                                        : fs_acc_reg[i][FR_SQ_STEPS-1];
                fm_r_reg[i]    <= fs_root_reg[i][FR_SQ_STEPS-1];
                fm_side_reg[i] <= fs_side_reg[i][FR_SQ_STEPS-1];
            end
        end
    end

    // ---------------- color combine ----------------
    side_t             pw_side;
    logic [LS_W-1:0]   ls1_reg [3];
    logic [LS_W-1:0]   dp1_reg [3];
    logic [X_W-1:0]    pw1_reg;
    logic [NDL_W-1:0]  ndl1_reg;
    logic              f1_v_reg;
    logic [S_W-1:0]    s2_reg [3];
    logic [D_W-1:0]    d2_reg [3];
    logic              f2_v_reg;
    logic [SUM_W-1:0]  sum_c [3];
    logic [2:0][15:0]  sat_c;

    assign pw_side = fm_side_reg[FRAC_STEPS-1];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sum_c[c] = SUM_W'(s2_reg[c] >> (COLOR_FRAC_BITS + FX_FRAC - PRE_SHIFT)) +
                       SUM_W'(d2_reg[c] >> (COLOR_FRAC_BITS + DIR_FRAC_BITS));
            sat_c[c] = (|sum_c[c][SUM_W-1:16]) ? 16'hFFFF : sum_c[c][15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_v_reg    <= 1'b0;
            f2_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            f1_v_reg    <= fm_v_reg[FRAC_STEPS-1];
            f2_v_reg    <= f1_v_reg;
            m_valid_reg <= f2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                ls1_reg[c] <= LS_W'(pw_side.light[c]) * LS_W'(spec_reg[c]);
                dp1_reg[c] <= LS_W'(diff_reg[c]) * LS_W'(pw_side.light[c]);
                s2_reg[c]  <= S_W'(ls1_reg[c][LS_W-1:PRE_SHIFT]) * S_W'(pw1_reg);
                d2_reg[c]  <= D_W'(dp1_reg[c]) * D_W'(ndl1_reg);
            end
            pw1_reg  <= pw_side.nz ? fm_acc_reg[FRAC_STEPS-1] : '0;
            ndl1_reg <= pw_side.ndotl;
            m_data_reg.out_red   <= sat_c[0];
            m_data_reg.out_green <= sat_c[1];
            m_data_reg.out_blue  <= sat_c[2];
        end
    end

    // ---------------- checks ----------------
    a_ndoth_le_one: assert property (@(posedge aclk) disable iff (!aresetn)
        ia_v_reg[0] |-> (ia_x_reg[0] <= ONE_Q30))
        else $error("normalized N.H above 1.0");

    a_div_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_v_reg[DIV_STEPS] && dv_side_reg[DIV_STEPS].pos &&
         !dv_side_reg[DIV_STEPS].clamp && dv_side_reg[DIV_STEPS].nz)
        |-> (dv_rem_reg[DIV_STEPS] < dv_lsq_reg[DIV_STEPS]))
        else $error("divider remainder not below divisor");

    a_pow_le_one: assert property (@(posedge aclk) disable iff (!aresetn)
        fm_v_reg[FRAC_STEPS-1] |-> (fm_acc_reg[FRAC_STEPS-1] <= ONE_Q30))
        else $error("power result above 1.0");

endmodule

`default_nettype wire
